### hdl/lkvc_pkg.sv
// Package for the LRU key-value cache: field widths, action codes and the
// stored key/value record. Depends on nothing; the top level and the testbench use it.
package lkvc_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned KEY_W = 32;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned CAP_W = 5;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request action codes.
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_ACCESS = 1'b1;

   // Key and value as held in one cache entry.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } kv_type;

endpackage

### hdl/lkvc_mem.sv
// Entry memory for the LRU key-value cache: one write port and one read port,
// read data registered. Depends on nothing.
module lkvc_mem #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4,
   parameter int unsigned DATA_W = 68
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Synchronous write; the entries have no reset value.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Synchronous read, old data on a same-cycle write to the same entry.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request sequencer, capacity register
// and result register. Depends on lkvc_pkg and lkvc_mem.
//
// Usage:
//   A request transaction is taken at a rising edge with start high and busy
//   low; req_action selects add (store or update) or access (look up).
//   Each access gives one result transaction: rsp_valid is high for exactly
//   one cycle with rsp_hit and rsp_read_value (zero on a miss). Adds give no
//   result. The receiver cannot stall the result; it must take it that cycle.
//   csr_data sets the number of entries that may be filled before eviction;
//   it is written when csr_valid and csr_ready are high (ready while idle).
// Sequence, with F the number of filled entries:
//   The entry memory has one read and one write port, and every request
//   scans all F entries through it one per cycle, decides, and then, except
//   on an access miss, rewrites the age ranks in a second pass (F or F + 1
//   entries). An access result is registered in the decide state. busy
//   stays high until the request is done; with start held high a new
//   request is taken in the cycle after busy falls.
// Reset:
//   Synchronous reset empties the cache (fill count zero), sets the capacity
//   to 16 and returns the sequencer to idle. No clearing pass is needed.
module lru_key_value_cache #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::VAL_W-1:0]   req_value,
   // Result channel.
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic signed [lkvc_pkg::VAL_W-1:0]   rsp_read_value,
   // Capacity register write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_data
);

   localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
   localparam int unsigned ENT_W = lkvc_pkg::KEY_W + lkvc_pkg::VAL_W + IDX_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              filled_ff, filled_in;
   logic [lkvc_pkg::CAP_W-1:0]    cap_ff, cap_in;

   // Latched request.
   logic                          act_ff, act_in;
   logic [lkvc_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lkvc_pkg::VAL_W-1:0]    val_ff, val_in;

   // Scan findings.
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic [IDX_W-1:0]              hit_rank_ff, hit_rank_in;
   logic [lkvc_pkg::VAL_W-1:0]    hit_val_ff, hit_val_in;
   logic [IDX_W-1:0]              old_slot_ff, old_slot_in;

   // Update pass plan.
   logic [IDX_W-1:0]              tgt_ff, tgt_in;
   logic [IDX_W-1:0]              thr_ff, thr_in;
   logic                          ins_ff, ins_in;
   logic [CNT_W-1:0]              len_ff, len_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lkvc_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;

   // Memory port signals.
   logic [IDX_W-1:0]              mem_raddr;
   logic [ENT_W-1:0]              mem_rdata;
   logic                          mem_we;
   logic [IDX_W-1:0]              mem_waddr;
   logic [ENT_W-1:0]              mem_wdata;

   // Helpers.
   lkvc_pkg::kv_type              rd_kv;
   lkvc_pkg::kv_type              wr_kv;
   logic [IDX_W-1:0]              rd_rank;
   logic [IDX_W-1:0]              wr_rank;
   logic [CNT_W-1:0]              cnt_m1;
   logic [IDX_W-1:0]              idx;
   logic [CNT_W-1:0]              filled_m1;
   logic [IDX_W-1:0]              oldest_rank;
   logic [lkvc_pkg::CAP_W-1:0]    cap_eff;
   logic                          room;

   lkvc_mem #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IDX_W),
      .DATA_W (ENT_W)
   ) u_mem (
      .clock   (clock),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   // Entry fields from the memory read data.
   assign rd_kv   = lkvc_pkg::kv_type'(mem_rdata[ENT_W-1:IDX_W]);
   assign rd_rank = mem_rdata[IDX_W-1:0];

   // The entry whose data is on the read port is one behind the counter.
   assign cnt_m1      = cnt_ff - CNT_W'(1);
   assign idx         = cnt_m1[IDX_W-1:0];
   assign filled_m1   = filled_ff - CNT_W'(1);
   assign oldest_rank = filled_m1[IDX_W-1:0];

   // A free slot exists below the effective capacity (zero acts as one).
   assign cap_eff = (cap_ff == '0) ? lkvc_pkg::CAP_W'(1) : cap_ff;
   assign room    = (CMP_W'(filled_ff) < CMP_W'(cap_eff)) &&
                    (CMP_W'(filled_ff) < CMP_W'(MAX_ENTRIES));

   assign mem_raddr = cnt_ff[IDX_W-1:0];
   assign mem_waddr = idx;
   assign mem_wdata = {wr_kv, wr_rank};

   // Handshake outputs.
   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // Rewritten entry in the update pass: the target becomes most recent,
   // entries younger than the threshold age by one.
   always_comb begin
      wr_kv   = rd_kv;
      wr_rank = rd_rank;
      if (idx == tgt_ff) begin
         wr_kv.key   = key_ff;
         wr_kv.value = (act_ff == lkvc_pkg::ACT_ACCESS) ? rd_kv.value : val_ff;
         wr_rank     = '0;
      end else if (rd_rank < thr_ff) begin
         wr_rank = rd_rank + IDX_W'(1);
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      filled_in    = filled_ff;
      cap_in       = cap_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      old_slot_in  = old_slot_ff;
      tgt_in       = tgt_ff;
      thr_in       = thr_ff;
      ins_in       = ins_ff;
      len_in       = len_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;

      // Capacity register write.
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in   = req_action;
               key_in   = req_key;
               val_in   = req_value;
               found_in = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end

         // Compare each filled entry against the key and note the oldest one.
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               if (!found_ff && (rd_kv.key == key_ff)) begin
                  found_in    = 1'b1;
                  slot_in     = idx;
                  hit_rank_in = rd_rank;
                  hit_val_in  = rd_kv.value;
               end
               if (rd_rank == oldest_rank) begin
                  old_slot_in = idx;
               end
            end
            if (cnt_ff == filled_ff) begin
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         // Issue the result of an access and plan the rank update pass.
         ST_DECIDE: begin
            cnt_in = '0;
            ins_in = 1'b0;
            len_in = filled_ff;
            if (act_ff == lkvc_pkg::ACT_ACCESS) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_value_in = found_ff ? hit_val_ff : '0;
               tgt_in       = slot_ff;
               thr_in       = hit_rank_ff;
               state_in     = found_ff ? ST_UPDATE : ST_IDLE;
            end else if (found_ff) begin
               tgt_in   = slot_ff;
               thr_in   = hit_rank_ff;
               state_in = ST_UPDATE;
            end else if (room) begin
               // New entry in the next free slot; every filled entry ages.
               tgt_in   = filled_ff[IDX_W-1:0];
               thr_in   = filled_ff[IDX_W-1:0];
               ins_in   = 1'b1;
               len_in   = filled_ff + CNT_W'(1);
               state_in = ST_UPDATE;
            end else begin
               // Replace the least recently used entry.
               tgt_in   = old_slot_ff;
               thr_in   = oldest_rank;
               state_in = ST_UPDATE;
            end
         end

         // Read, modify and write back each entry, one per cycle.
         ST_UPDATE: begin
            if (cnt_ff != '0) begin
               mem_we = 1'b1;
            end
            if (cnt_ff == len_ff) begin
               state_in = ST_IDLE;
               if (ins_ff) begin
                  filled_in = filled_ff + CNT_W'(1);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      act_ff       <= act_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      old_slot_ff  <= old_slot_in;
      tgt_ff       <= tgt_in;
      thr_ff       <= thr_in;
      ins_ff       <= ins_in;
      len_ff       <= len_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTHESIS
   // A taken request makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // The fill count never exceeds the number of entries.
   a_filled_max: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill count beyond entry count");

   // A miss result carries a zero value.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == '0))
      else $error("miss result with nonzero value");

   // Results only follow a cycle in which a request was in progress.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for lru_key_value_cache: directed and random add/access traffic
// checked against a behavioral LRU cache predictor. Depends on lkvc_pkg and lru_key_value_cache.
module tb;

   localparam int unsigned NUM_SLOTS     = 16;
   localparam int unsigned POOL_SIZE     = 24;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
   localparam int unsigned TAIL_CYCLES   = 80;
   localparam int unsigned CYCLE_LIMIT   = 600000;

   // Work items queued for the driver.
   typedef enum logic [1:0] {
      CMD_REQ,
      CMD_SYNC,
      CMD_CFG
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic                         action;
      logic [lkvc_pkg::KEY_W-1:0]   key;
      logic [lkvc_pkg::VAL_W-1:0]   value;
      logic [lkvc_pkg::CAP_W-1:0]   cap;
   } cache_cmd_type;

   typedef struct packed {
      logic                         hit;
      logic [lkvc_pkg::VAL_W-1:0]   value;
   } read_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                              start      = 1'b0;
   logic                              busy;
   logic                              req_action = lkvc_pkg::ACT_ADD;
   logic signed [lkvc_pkg::KEY_W-1:0] req_key    = '0;
   logic signed [lkvc_pkg::VAL_W-1:0] req_value  = '0;
   logic                              rsp_valid;
   logic                              rsp_hit;
   logic signed [lkvc_pkg::VAL_W-1:0] rsp_read_value;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [lkvc_pkg::CAP_W-1:0]        csr_data   = '0;

   cache_cmd_type   cmd_queue[$];
   read_result_type predicted_reads[$];
   read_result_type observed_read;

   // Predictor state: a shadow of the cache contents and its capacity.
   logic [lkvc_pkg::KEY_W-1:0] cache_keys [NUM_SLOTS];
   logic [lkvc_pkg::VAL_W-1:0] cache_vals [NUM_SLOTS];
   int unsigned                cache_ranks[NUM_SLOTS];
   int unsigned                fill_count;
   logic [lkvc_pkg::CAP_W-1:0] cap_setting;

   logic [lkvc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned gap_left;
   int unsigned no_idle_left;
   int unsigned settle_count;
   int unsigned gap_roll;
   logic        start_next;
   logic        csr_next;

   lru_key_value_cache #(
      .MAX_ENTRIES(NUM_SLOTS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   // Clock and the single reset at the start of the run.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string what, logic [lkvc_pkg::VAL_W-1:0] want,
                                  logic [lkvc_pkg::VAL_W-1:0] got);
      $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Makes slot s the most recent entry; every younger entry ages by one.
   function automatic void promote_slot(int unsigned s);
      int unsigned r;
      r = cache_ranks[s];
      for (int unsigned i = 0; i < fill_count; i++)
         if (cache_ranks[i] < r) cache_ranks[i]++;
      cache_ranks[s] = 0;
   endfunction

   // Applies one accepted request to the shadow cache and queues the
   // read result that an access transaction must produce.
   function automatic void predict_request(logic act, logic [lkvc_pkg::KEY_W-1:0] k,
                                           logic [lkvc_pkg::VAL_W-1:0] v);
      int              slot;
      int unsigned     lim;
      int unsigned     oldest;
      read_result_type res;
      slot = -1;
      for (int unsigned i = 0; i < fill_count; i++)
         if (slot < 0 && cache_keys[i] == k) slot = i;

      if (act == lkvc_pkg::ACT_ACCESS) begin
         if (slot >= 0) begin
            res.hit   = 1'b1;
            res.value = cache_vals[slot];
            promote_slot(slot);
         end else begin
            res.hit   = 1'b0;
            res.value = '0;
         end
         predicted_reads.push_back(res);
         return;
      end

      // Zero acts as one and anything above the slot count as the slot count.
      lim = (cap_setting == 0) ? 1 : (cap_setting > NUM_SLOTS) ? NUM_SLOTS : cap_setting;
      if (slot >= 0) begin
         cache_vals[slot] = v;
         promote_slot(slot);
      end else if (fill_count < lim) begin
         for (int unsigned i = 0; i < fill_count; i++) cache_ranks[i]++;
         cache_keys[fill_count]  = k;
         cache_vals[fill_count]  = v;
         cache_ranks[fill_count] = 0;
         fill_count++;
      end else begin
         // Evict the least recently used filled entry.
         oldest = 0;
         for (int unsigned i = 1; i < fill_count; i++)
            if (cache_ranks[i] > cache_ranks[oldest]) oldest = i;
         cache_keys[oldest] = k;
         cache_vals[oldest] = v;
         promote_slot(oldest);
      end
   endfunction

   // Stimulus queue helpers.
   task automatic push_req(logic act, logic [lkvc_pkg::KEY_W-1:0] k,
                           logic [lkvc_pkg::VAL_W-1:0] v);
      cache_cmd_type c;
      c = '0;
      c.kind   = CMD_REQ;
      c.action = act;
      c.key    = k;
      c.value  = v;
      cmd_queue.push_back(c);
   endtask

   task automatic push_sync();
      cache_cmd_type c;
      c = '0;
      c.kind = CMD_SYNC;
      cmd_queue.push_back(c);
   endtask

   task automatic push_cfg(logic [lkvc_pkg::CAP_W-1:0] cap);
      cache_cmd_type c;
      c = '0;
      c.kind = CMD_CFG;
      c.cap  = cap;
      cmd_queue.push_back(c);
   endtask

   // Driver: request transactions with random gaps, capacity writes only
   // after the cache has drained and settled.
   always @(posedge clock) begin
      if (reset) begin
         start        <= 1'b0;
         csr_valid    <= 1'b0;
         gap_left     = 0;
         no_idle_left = 0;
         settle_count = 0;
         fill_count   = 0;
         cap_setting  = lkvc_pkg::CAP_RESET;
      end else begin
         start_next = start;
         csr_next   = csr_valid;

         if (start && !busy) begin
            predict_request(req_action, req_key, req_value);
            start_next = 1'b0;
            // Mostly short gaps, a few long ones, and stretches with none.
            if (no_idle_left != 0) begin
               no_idle_left--;
               gap_left = 0;
            end else begin
               gap_roll = $urandom_range(0, 99);
               if (gap_roll < 10) begin
                  no_idle_left = $urandom_range(20, 60);
                  gap_left = 0;
               end else if (gap_roll < 80)
                  gap_left = $urandom_range(0, 3);
               else if (gap_roll < 95)
                  gap_left = $urandom_range(4, 20);
               else
                  gap_left = $urandom_range(21, 60);
            end
         end

         if (csr_valid && csr_ready) begin
            cap_setting = csr_data;
            csr_next    = 1'b0;
         end

         if (!start_next && !csr_next && cmd_queue.size() != 0) begin
            if (gap_left != 0)
               gap_left--;
            else begin
               case (cmd_queue[0].kind)
                  CMD_REQ: begin
                     req_action <= cmd_queue[0].action;
                     req_key    <= cmd_queue[0].key;
                     req_value  <= cmd_queue[0].value;
                     start_next = 1'b1;
                     cmd_queue.delete(0);
                  end
                  CMD_SYNC: begin
                     // Hold off until every read has come back, then let the
                     // last add finish its rank pass.
                     if (predicted_reads.size() != 0)
                        settle_count = 0;
                     else if (settle_count < SETTLE_CYCLES)
                        settle_count++;
                     else begin
                        settle_count = 0;
                        cmd_queue.delete(0);
                     end
                  end
                  default: begin
                     csr_data <= cmd_queue[0].cap;
                     csr_next = 1'b1;
                     cmd_queue.delete(0);
                  end
               endcase
            end
         end

         start     <= start_next;
         csr_valid <= csr_next;
      end
   end

   // Monitor: each result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (predicted_reads.size() == 0)
            report_mismatch("unexpected result, read_value", '0, rsp_read_value);
         else begin
            observed_read = predicted_reads.pop_front();
            if (rsp_hit !== observed_read.hit)
               report_mismatch("hit", lkvc_pkg::VAL_W'(observed_read.hit),
                               lkvc_pkg::VAL_W'(rsp_hit));
            if (rsp_read_value !== observed_read.value)
               report_mismatch("read_value", observed_read.value, rsp_read_value);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus plan and end of run.
   initial begin
      int unsigned pool_span;
      int unsigned roll;
      logic [lkvc_pkg::KEY_W-1:0] k;
      logic [lkvc_pkg::VAL_W-1:0] v;
      logic [lkvc_pkg::CAP_W-1:0] phase_caps[10];

      // Capacity of one: fill, update, evict, and a miss on the empty cache.
      push_cfg(5'd1);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h8000_0000, 32'h0);
      push_req(lkvc_pkg::ACT_ADD,    32'h8000_0000, 32'h7FFF_FFFF);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h8000_0000, 32'hFFFF_FFFF);
      push_req(lkvc_pkg::ACT_ADD,    32'h8000_0000, 32'h8000_0000);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h8000_0000, 32'h0);
      push_req(lkvc_pkg::ACT_ADD,    32'h7FFF_FFFF, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h8000_0000, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h7FFF_FFFF, 32'h0);

      // A capacity of zero behaves as one.
      push_sync();
      push_cfg(5'd0);
      push_req(lkvc_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(lkvc_pkg::ACT_ACCESS, 32'hFFFF_FFFF, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h7FFF_FFFF, 32'h0);

      // Capacity three: recency decides which entry is replaced.
      push_sync();
      push_cfg(5'd3);
      push_req(lkvc_pkg::ACT_ADD,    32'h0000_0000, 32'h0000_0001);
      push_req(lkvc_pkg::ACT_ADD,    32'h0000_0001, 32'h5555_5555);
      push_req(lkvc_pkg::ACT_ACCESS, 32'hFFFF_FFFF, 32'h0);
      push_req(lkvc_pkg::ACT_ADD,    32'hAAAA_AAAA, 32'hAAAA_AAAA);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h0000_0000, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h0000_0001, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'hAAAA_AAAA, 32'h0);

      // Capacity lowered below the fill count: nothing dropped, LRU replaced.
      push_sync();
      push_cfg(5'd2);
      push_req(lkvc_pkg::ACT_ADD,    32'h0000_0000, 32'h1234_5678);
      push_req(lkvc_pkg::ACT_ACCESS, 32'hFFFF_FFFF, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h0000_0001, 32'h0);
      push_req(lkvc_pkg::ACT_ACCESS, 32'h0000_0000, 32'h0);

      // Key pool: extremes plus random patterns, a bit larger than the cache.
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = 32'h7FFF_FFFF;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int unsigned i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

      phase_caps[0] = 5'd4;
      phase_caps[1] = 5'd2;
      phase_caps[2] = 5'd31;
      phase_caps[3] = 5'd16;
      phase_caps[4] = 5'd0;
      phase_caps[5] = 5'd1;
      phase_caps[6] = 5'd17;
      phase_caps[7] = 5'd9;
      phase_caps[8] = lkvc_pkg::CAP_W'($urandom_range(0, 31));
      phase_caps[9] = lkvc_pkg::CAP_W'($urandom_range(0, 31));

      // Random phases, each at its own capacity and key spread.
      for (int unsigned p = 0; p < 10; p++) begin
         push_sync();
         push_cfg(phase_caps[p]);
         pool_span = $urandom_range(2, POOL_SIZE);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            k = (roll < 88) ? key_pool[$urandom_range(0, pool_span - 1)] : $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 3)
               v = 32'h8000_0000;
            else if (roll < 6)
               v = 32'h7FFF_FFFF;
            else
               v = $urandom();
            push_req(1'($urandom_range(0, 1)), k, v);
            if ($urandom_range(0, 99) == 0) push_sync();
         end
      end

      while (cmd_queue.size() != 0 || start || csr_valid || predicted_reads.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
